[rtl/jtok_pkg.sv]
// payload types and character constants for the json array tokenizer
// no dependencies; used by the interfaces, jtok_fsm and json_object_array_tokenizer

package jtok_pkg;

	localparam logic [7:0] CH_LBRACK    = 8'h5b; // [
	localparam logic [7:0] CH_RBRACK    = 8'h5d; // ]
	localparam logic [7:0] CH_LBRACE    = 8'h7b; // {
	localparam logic [7:0] CH_RBRACE    = 8'h7d; // }
	localparam logic [7:0] CH_COLON     = 8'h3a; // :
	localparam logic [7:0] CH_COMMA     = 8'h2c; // ,
	localparam logic [7:0] CH_QUOTE     = 8'h22; // "
	localparam logic [7:0] CH_BACKSLASH = 8'h5c; // backslash
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_LF        = 8'h0a;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_N         = 8'h6e; // n
	localparam logic [7:0] CH_R         = 8'h72; // r
	localparam logic [7:0] CH_T         = 8'h74; // t

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} text_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       in_key;
		logic       key_end;
		logic       value_end;
		logic       object_end;
		logic       array_end;
		logic       not_array;
	} token_t;

endpackage

[rtl/jtok_if.sv]
// valid/ready channel interfaces for document bytes and tokens
// depends on jtok_pkg for the payload types

interface jtok_text_if;
	logic            valid;
	logic            ready;
	jtok_pkg::text_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface jtok_token_if;
	logic             valid;
	logic             ready;
	jtok_pkg::token_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/jtok_fsm.sv]
// parse phase machine and result register of the json array tokenizer
// depends on jtok_pkg

module jtok_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jtok_pkg::text_t  text,
	output jtok_pkg::token_t token
);

	typedef enum logic [3:0] {
		PH_START,
		PH_ARRAY,
		PH_OBJ,
		PH_KEY,
		PH_KEY_ESC,
		PH_COLON,
		PH_VALWS,
		PH_VBARE,
		PH_VSTR,
		PH_VSTR_ESC,
		PH_DONE
	} phase_t;

	phase_t           phase_q;
	phase_t           phase_d;
	phase_t           phase_mid;
	jtok_pkg::token_t token_q;
	jtok_pkg::token_t token_d;
	logic [7:0]       c;
	logic             last;
	logic             ws;
	logic [7:0]       unesc;

	assign c    = text.in_byte;
	assign last = text.last_byte;
	assign ws   = (c == jtok_pkg::CH_SPACE) || (c == jtok_pkg::CH_LF) ||
	              (c == jtok_pkg::CH_CR) || (c == jtok_pkg::CH_TAB);

	always_comb begin
		case (c)
			jtok_pkg::CH_N: unesc = jtok_pkg::CH_LF;
			jtok_pkg::CH_R: unesc = jtok_pkg::CH_CR;
			jtok_pkg::CH_T: unesc = jtok_pkg::CH_TAB;
			default:        unesc = c;
		endcase
	end

	always_comb begin
		token_d   = '0;
		phase_mid = phase_q;
		case (phase_q)
			PH_START: begin
				if (c == jtok_pkg::CH_LBRACK) begin
					phase_mid = PH_ARRAY;
				end else if (!ws) begin
					token_d.not_array = 1'b1;
					token_d.array_end = 1'b1;
					phase_mid         = PH_DONE;
				end
			end
			PH_ARRAY: begin
				if (c == jtok_pkg::CH_RBRACK) begin
					token_d.array_end = 1'b1;
					phase_mid         = PH_DONE;
				end else if (c == jtok_pkg::CH_LBRACE) begin
					phase_mid = PH_OBJ;
				end
			end
			PH_OBJ: begin
				if (c == jtok_pkg::CH_RBRACE) begin
					token_d.object_end = 1'b1;
					phase_mid          = PH_ARRAY;
				end else if (c == jtok_pkg::CH_QUOTE) begin
					phase_mid = PH_KEY;
				end
			end
			PH_KEY, PH_VSTR: begin
				if (c == jtok_pkg::CH_QUOTE) begin
					if (phase_q == PH_KEY) begin
						token_d.key_end = 1'b1;
						phase_mid       = PH_COLON;
					end else begin
						token_d.value_end = 1'b1;
						phase_mid         = PH_OBJ;
					end
				end else if (c == jtok_pkg::CH_BACKSLASH && !last) begin
					phase_mid = (phase_q == PH_KEY) ? PH_KEY_ESC : PH_VSTR_ESC;
				end else begin
					// a trailing backslash on the last byte lands here too
					token_d.out_char   = c;
					token_d.char_valid = 1'b1;
					token_d.in_key     = (phase_q == PH_KEY);
				end
			end
			PH_KEY_ESC, PH_VSTR_ESC: begin
				token_d.out_char   = unesc;
				token_d.char_valid = 1'b1;
				token_d.in_key     = (phase_q == PH_KEY_ESC);
				phase_mid          = (phase_q == PH_KEY_ESC) ? PH_KEY : PH_VSTR;
			end
			PH_COLON, PH_VALWS: begin
				if (ws) begin
					phase_mid = phase_q;
				end else if (phase_q == PH_COLON && c == jtok_pkg::CH_COLON) begin
					phase_mid = PH_VALWS;
				end else if (c == jtok_pkg::CH_QUOTE) begin
					phase_mid = PH_VSTR;
				end else if (c == jtok_pkg::CH_COMMA || c == jtok_pkg::CH_RBRACK) begin
					// empty value
					token_d.value_end = 1'b1;
					phase_mid         = PH_OBJ;
				end else if (c == jtok_pkg::CH_RBRACE) begin
					token_d.value_end  = 1'b1;
					token_d.object_end = 1'b1;
					phase_mid          = PH_ARRAY;
				end else begin
					token_d.out_char   = c;
					token_d.char_valid = 1'b1;
					phase_mid          = PH_VBARE;
				end
			end
			PH_VBARE: begin
				if (ws || c == jtok_pkg::CH_COMMA || c == jtok_pkg::CH_RBRACK) begin
					token_d.value_end = 1'b1;
					phase_mid         = PH_OBJ;
				end else if (c == jtok_pkg::CH_RBRACE) begin
					token_d.value_end  = 1'b1;
					token_d.object_end = 1'b1;
					phase_mid          = PH_ARRAY;
				end else begin
					token_d.out_char   = c;
					token_d.char_valid = 1'b1;
				end
			end
			default: begin
				phase_mid = PH_DONE;
			end
		endcase

		phase_d = phase_mid;
		if (last) begin
			// close whatever is still open, then restart on the next byte
			case (phase_mid)
				PH_START: begin
					token_d.not_array = 1'b1;
					token_d.array_end = 1'b1;
				end
				PH_ARRAY: begin
					token_d.array_end = 1'b1;
				end
				PH_OBJ: begin
					token_d.object_end = 1'b1;
					token_d.array_end  = 1'b1;
				end
				PH_KEY, PH_KEY_ESC: begin
					token_d.key_end    = 1'b1;
					token_d.value_end  = 1'b1;
					token_d.object_end = 1'b1;
					token_d.array_end  = 1'b1;
				end
				PH_COLON, PH_VALWS, PH_VBARE, PH_VSTR, PH_VSTR_ESC: begin
					token_d.value_end  = 1'b1;
					token_d.object_end = 1'b1;
					token_d.array_end  = 1'b1;
				end
				default: begin
				end
			endcase
			phase_d = PH_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			token_q <= '0;
		end else if (load) begin
			phase_q <= phase_d;
			token_q <= token_d;
		end
	end

	assign token = token_q;

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		load && last |=> phase_q == PH_START)
		else $error("phase not back at start after last byte");

	a_not_array_ends: assert property (@(posedge clk) disable iff (!arst_n)
		token_q.not_array |-> token_q.array_end && !token_q.char_valid)
		else $error("not_array without array_end");

	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!token_q.char_valid |-> token_q.out_char == 8'h00 && !token_q.in_key)
		else $error("character fields set without char_valid");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		load && phase_q == PH_DONE && !last |=> token_q == '0 && phase_q == PH_DONE)
		else $error("done phase produced a token");

endmodule

[rtl/json_object_array_tokenizer.sv]
// top level of the json array tokenizer: input stage, phase machine, output valid
// depends on jtok_pkg, jtok_if.sv (jtok_text_if, jtok_token_if) and jtok_fsm

// Usage
//   text   : sink channel, one document byte per transfer (in_byte, last_byte)
//   tokens : source channel, exactly one token per accepted byte
//   A byte is captured in an input register, decoded combinationally by the
//   phase machine and lands in the token register; its token is valid once
//   it sits there. One byte per cycle is sustained while the sink keeps
//   ready high.
//   When the sink stalls, the token register holds, the input register keeps
//   one more byte, and text.ready drops only once both are full; ready returns
//   in the cycle the held token transfers, so no bubble is inserted.
//   last_byte closes any open key, value or object and arms the phase machine
//   for a new document on the next byte.
//   Reset clears both valid flags and returns the parser to waiting for '['.

module json_object_array_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	jtok_text_if.sink           text,
	jtok_token_if.source        tokens
);

	logic            valid_s1;
	jtok_pkg::text_t data_s1;
	logic            out_valid_q;
	logic            advance;
	logic            load;
	logic            take;

	// stage 1 may move forward when the token register is empty or draining
	assign advance    = !out_valid_q || tokens.ready;
	assign load       = valid_s1 && advance;
	assign text.ready = !valid_s1 || advance;
	assign take       = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= text.data;
		end
	end

	jtok_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.text   (data_s1),
		.token  (tokens.data)
	);

	assign tokens.valid = out_valid_q;

endmodule

[dv/json_object_array_tokenizer_tb.sv]
// self-checking testbench for json_object_array_tokenizer: directed documents, then random ones
// depends on jtok_pkg, jtok_text_if and jtok_token_if from rtl, and on the block itself

module json_object_array_tokenizer_tb;

	typedef logic [7:0] byte_q_t[$];

	// parse position of the document currently entering the block
	typedef enum logic [3:0] {
		WAIT_OPEN,
		IN_ARRAY,
		IN_OBJECT,
		KEY_TEXT,
		KEY_ESCAPE,
		AFTER_KEY,
		VALUE_START,
		BARE_VALUE,
		STRING_VALUE,
		STRING_ESCAPE,
		PARSE_DONE
	} doc_phase_t;

	localparam int LONG_STALL = 60;       // receiver hold-off, in cycles
	localparam int PHASE_BYTES = 530;     // random bytes per idling phase

	logic clk;
	logic arst_n;

	jtok_text_if  text_ch();
	jtok_token_if token_ch();

	json_object_array_tokenizer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.tokens (token_ch)
	);

	// predictor state and the tokens still owed by the block
	doc_phase_t       doc_phase = WAIT_OPEN;
	jtok_pkg::token_t pending_tokens[$];

	int send_idle_pct;
	int recv_idle_pct;
	int stall_request;
	int bytes_sent;
	int tokens_seen;
	int docs_sent;
	int mismatches;
	int chars_seen;
	int keys_seen;
	int objects_seen;
	int rejected_docs;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// generous fixed limit, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("json_object_array_tokenizer_tb: done, errors");
		$finish;
	end

	function automatic logic is_blank(logic [7:0] c);
		return c == jtok_pkg::CH_SPACE || c == jtok_pkg::CH_LF ||
		       c == jtok_pkg::CH_CR || c == jtok_pkg::CH_TAB;
	endfunction

	function automatic logic [7:0] decode_escape(logic [7:0] c);
		case (c)
			jtok_pkg::CH_N: return jtok_pkg::CH_LF;
			jtok_pkg::CH_R: return jtok_pkg::CH_CR;
			jtok_pkg::CH_T: return jtok_pkg::CH_TAB;
			default:        return c;
		endcase
	endfunction

	// token for one document byte; advances doc_phase
	function automatic jtok_pkg::token_t next_token(jtok_pkg::text_t t);
		jtok_pkg::token_t tok;
		doc_phase_t       ph;
		logic [7:0]       c;
		logic             key;
		tok = '0;
		c   = t.in_byte;
		ph  = doc_phase;
		key = (ph == KEY_TEXT);
		case (ph)
			WAIT_OPEN: begin
				if (c == jtok_pkg::CH_LBRACK) begin
					ph = IN_ARRAY;
				end else if (!is_blank(c)) begin
					tok.not_array = 1'b1;
					tok.array_end = 1'b1;
					ph = PARSE_DONE;
				end
			end
			IN_ARRAY: begin
				if (c == jtok_pkg::CH_RBRACK) begin
					tok.array_end = 1'b1;
					ph = PARSE_DONE;
				end else if (c == jtok_pkg::CH_LBRACE) begin
					ph = IN_OBJECT;
				end
			end
			IN_OBJECT: begin
				if (c == jtok_pkg::CH_RBRACE) begin
					tok.object_end = 1'b1;
					ph = IN_ARRAY;
				end else if (c == jtok_pkg::CH_QUOTE) begin
					ph = KEY_TEXT;
				end
			end
			KEY_TEXT, STRING_VALUE: begin
				if (c == jtok_pkg::CH_QUOTE) begin
					if (key) begin
						tok.key_end = 1'b1;
						ph = AFTER_KEY;
					end else begin
						tok.value_end = 1'b1;
						ph = IN_OBJECT;
					end
				end else if (c == jtok_pkg::CH_BACKSLASH && !t.last_byte) begin
					ph = key ? KEY_ESCAPE : STRING_ESCAPE;
				end else begin
					// a backslash on the final byte lands here and stays literal
					tok.out_char   = c;
					tok.char_valid = 1'b1;
					tok.in_key     = key;
				end
			end
			KEY_ESCAPE: begin
				tok.out_char   = decode_escape(c);
				tok.char_valid = 1'b1;
				tok.in_key     = 1'b1;
				ph = KEY_TEXT;
			end
			STRING_ESCAPE: begin
				tok.out_char   = decode_escape(c);
				tok.char_valid = 1'b1;
				ph = STRING_VALUE;
			end
			AFTER_KEY, VALUE_START: begin
				if (!is_blank(c)) begin
					// the colon is only swallowed right after a key
					if (ph == AFTER_KEY && c == jtok_pkg::CH_COLON) begin
						ph = VALUE_START;
					end else if (c == jtok_pkg::CH_QUOTE) begin
						ph = STRING_VALUE;
					end else if (c == jtok_pkg::CH_COMMA || c == jtok_pkg::CH_RBRACK) begin
						tok.value_end = 1'b1;
						ph = IN_OBJECT;
					end else if (c == jtok_pkg::CH_RBRACE) begin
						tok.value_end  = 1'b1;
						tok.object_end = 1'b1;
						ph = IN_ARRAY;
					end else begin
						tok.out_char   = c;
						tok.char_valid = 1'b1;
						ph = BARE_VALUE;
					end
				end
			end
			BARE_VALUE: begin
				if (is_blank(c) || c == jtok_pkg::CH_COMMA || c == jtok_pkg::CH_RBRACK) begin
					tok.value_end = 1'b1;
					ph = IN_OBJECT;
				end else if (c == jtok_pkg::CH_RBRACE) begin
					tok.value_end  = 1'b1;
					tok.object_end = 1'b1;
					ph = IN_ARRAY;
				end else begin
					tok.out_char   = c;
					tok.char_valid = 1'b1;
				end
			end
			default: ph = PARSE_DONE;
		endcase

		// final byte: close whatever is still open, then rearm for a new document
		if (t.last_byte) begin
			case (ph)
				WAIT_OPEN: begin
					tok.not_array = 1'b1;
					tok.array_end = 1'b1;
				end
				IN_ARRAY: tok.array_end = 1'b1;
				IN_OBJECT: begin
					tok.object_end = 1'b1;
					tok.array_end  = 1'b1;
				end
				KEY_TEXT, KEY_ESCAPE: begin
					tok.key_end    = 1'b1;
					tok.value_end  = 1'b1;
					tok.object_end = 1'b1;
					tok.array_end  = 1'b1;
				end
				AFTER_KEY, VALUE_START, BARE_VALUE, STRING_VALUE, STRING_ESCAPE: begin
					tok.value_end  = 1'b1;
					tok.object_end = 1'b1;
					tok.array_end  = 1'b1;
				end
				default: ;
			endcase
			ph = WAIT_OPEN;
		end
		doc_phase = ph;
		return tok;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_flag(string name, logic want, logic got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
		end
	endtask

	// input transfers feed the predictor first, then output transfers are checked
	always @(posedge clk) begin
		jtok_pkg::token_t want;
		jtok_pkg::token_t got;
		if (text_ch.valid && text_ch.ready)
			pending_tokens = {pending_tokens, next_token(text_ch.data)};
		if (token_ch.valid && token_ch.ready) begin
			got = token_ch.data;
			tokens_seen++;
			chars_seen    += int'(got.char_valid);
			keys_seen     += int'(got.key_end);
			objects_seen  += int'(got.object_end);
			rejected_docs += int'(got.not_array);
			if (pending_tokens.size() == 0) begin
				mismatches++;
				$display("%0t: token with nothing pending, expected none actual %0h",
					$time, got);
			end else begin
				want = pending_tokens.pop_front();
				check_field("out_char",  want.out_char,   got.out_char);
				check_flag("char_valid", want.char_valid, got.char_valid);
				check_flag("in_key",     want.in_key,     got.in_key);
				check_flag("key_end",    want.key_end,    got.key_end);
				check_flag("value_end",  want.value_end,  got.value_end);
				check_flag("object_end", want.object_end, got.object_end);
				check_flag("array_end",  want.array_end,  got.array_end);
				check_flag("not_array",  want.not_array,  got.not_array);
			end
		end
	end

	// token sink: random stalls, plus a long hold-off whenever stall_request moves
	initial begin
		int hold_left;
		int seen_request;
		hold_left = 0;
		seen_request = 0;
		token_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request != seen_request) begin
				seen_request = stall_request;
				hold_left = LONG_STALL;
			end
			if (hold_left > 0) begin
				hold_left--;
				token_ch.ready <= 1'b0;
			end else begin
				token_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// one byte transfer; valid stays high into the next call unless it idles first
	task automatic send_byte(logic [7:0] b, logic is_last);
		jtok_pkg::text_t t;
		t.in_byte   = b;
		t.last_byte = is_last;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		text_ch.valid <= 1'b1;
		text_ch.data  <= t;
		do @(posedge clk); while (!text_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_text(string s, logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last_at_end && i == s.len() - 1);
	endtask

	task automatic send_document(byte_q_t doc);
		for (int i = 0; i < doc.size(); i++)
			send_byte(doc[i], i == doc.size() - 1);
		docs_sent++;
	endtask

	// each byte gives exactly one token, so counts tell when the block is empty
	task automatic wait_drained();
		while (tokens_seen < bytes_sent)
			@(posedge clk);
	endtask

	// append one byte to a document under construction
	task automatic add_byte(inout byte_q_t doc, input logic [7:0] b);
		doc = {doc, b};
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0:       return jtok_pkg::CH_SPACE;
			1:       return jtok_pkg::CH_LF;
			2:       return jtok_pkg::CH_CR;
			default: return jtok_pkg::CH_TAB;
		endcase
	endfunction

	// string body with a mix of plain bytes and escapes
	task automatic append_string_body(inout byte_q_t doc);
		logic [7:0] c;
		repeat ($urandom_range(0, 6)) begin
			if ($urandom_range(0, 99) < 15) begin
				add_byte(doc, jtok_pkg::CH_BACKSLASH);
				case ($urandom_range(0, 5))
					0:       add_byte(doc, jtok_pkg::CH_QUOTE);
					1:       add_byte(doc, jtok_pkg::CH_BACKSLASH);
					2:       add_byte(doc, jtok_pkg::CH_N);
					3:       add_byte(doc, jtok_pkg::CH_R);
					4:       add_byte(doc, jtok_pkg::CH_T);
					default: add_byte(doc, 8'($urandom_range(0, 255)));
				endcase
			end else begin
				c = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
				                                : 8'($urandom_range(8'h20, 8'h7e));
				if (c == jtok_pkg::CH_QUOTE || c == jtok_pkg::CH_BACKSLASH)
					c = jtok_pkg::CH_N;
				add_byte(doc, c);
			end
		end
	endtask

	// mostly well-formed arrays of objects, some cut short, corrupted or pure noise
	task automatic build_document(output byte_q_t doc);
		int n_obj;
		int n_mem;
		int cut;
		doc = {};
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 6)) add_byte(doc, 8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 99) < 20) add_byte(doc, pick_blank());
		add_byte(doc, jtok_pkg::CH_LBRACK);
		n_obj = $urandom_range(0, 3);
		for (int o = 0; o < n_obj; o++) begin
			if ($urandom_range(0, 99) < 30) add_byte(doc, pick_blank());
			add_byte(doc, jtok_pkg::CH_LBRACE);
			n_mem = $urandom_range(0, 3);
			for (int m = 0; m < n_mem; m++) begin
				if (m > 0)
					add_byte(doc, ($urandom_range(0, 3) == 0) ? pick_blank()
					                                          : jtok_pkg::CH_COMMA);
				if ($urandom_range(0, 99) < 25) add_byte(doc, pick_blank());
				add_byte(doc, jtok_pkg::CH_QUOTE);
				append_string_body(doc);
				add_byte(doc, jtok_pkg::CH_QUOTE);
				if ($urandom_range(0, 99) < 25) add_byte(doc, pick_blank());
				if ($urandom_range(0, 99) < 80) add_byte(doc, jtok_pkg::CH_COLON);
				if ($urandom_range(0, 99) < 25) add_byte(doc, pick_blank());
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						add_byte(doc, jtok_pkg::CH_QUOTE);
						append_string_body(doc);
						add_byte(doc, jtok_pkg::CH_QUOTE);
					end
					5, 6, 7: repeat ($urandom_range(1, 6))
						add_byte(doc, 8'($urandom_range(8'h21, 8'h7e)));
					8: ;  // empty value
					default: add_byte(doc, 8'($urandom_range(0, 255)));
				endcase
			end
			if ($urandom_range(0, 99) < 20) add_byte(doc, pick_blank());
			add_byte(doc, jtok_pkg::CH_RBRACE);
			if (o < n_obj - 1 && $urandom_range(0, 1) == 1) add_byte(doc, jtok_pkg::CH_COMMA);
		end
		add_byte(doc, jtok_pkg::CH_RBRACK);
		// trailing bytes after the array are ignored by the block
		if ($urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, 4)) add_byte(doc, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 99) < 25) begin
			cut = $urandom_range(1, doc.size());
			doc = doc[0:cut-1];
		end
		if ($urandom_range(0, 99) < 5)
			doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
	endtask

	// rejected documents: stray first byte with ignored rest, and a blank document
	task automatic test_not_array();
		send_byte(jtok_pkg::CH_COMMA, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(jtok_pkg::CH_SPACE, 1'b1);
		docs_sent += 2;
	endtask

	// key escape, bare value ended by blank, colon opening a bare value, object
	// and array close, then a zero byte ignored after the end
	task automatic test_members();
		send_text("[{\"\\n\":x \"b\"::y}]", 1'b0);
		send_byte(8'h00, 1'b1);
		docs_sent++;
	endtask

	// empty value before a comma, string escapes incl. pass-through, stray
	// bracket between members, high byte in a value, backslash as final byte
	task automatic test_strings_and_empty_values();
		send_text("[{\"k\",}{\"v\"\"\\\\\\q\\\"\\t\"]\"x\":\"", 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(jtok_pkg::CH_BACKSLASH, 1'b1);
		docs_sent++;
	endtask

	// long receiver hold-off while bytes keep coming, then a pause until empty
	task automatic test_backpressure();
		byte_q_t doc;
		int saved_pct;
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		stall_request++;
		for (int i = 0; i < 3; i++) begin
			build_document(doc);
			send_document(doc);
		end
		text_ch.valid <= 1'b0;
		wait_drained();
		send_idle_pct = saved_pct;
	endtask

	task automatic test_random(int send_pct, int recv_pct);
		byte_q_t doc;
		int start_bytes;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < PHASE_BYTES) begin
			build_document(doc);
			send_document(doc);
		end
	endtask

	initial begin
		text_ch.valid = 1'b0;
		text_ch.data  = '0;
		arst_n        = 1'b0;
		send_idle_pct = 21;
		recv_idle_pct = 68;
		stall_request = 0;
		bytes_sent    = 0;
		tokens_seen   = 0;
		docs_sent     = 0;
		mismatches    = 0;
		chars_seen    = 0;
		keys_seen     = 0;
		objects_seen  = 0;
		rejected_docs = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_not_array();
		test_members();
		test_strings_and_empty_values();
		test_backpressure();
		test_random(21, 68);
		test_random(68, 21);
		test_random(0, 0);

		text_ch.valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);

		$display("%0d documents, %0d byte transfers, %0d tokens checked", docs_sent,
			bytes_sent, tokens_seen);
		$display("%0d characters, %0d keys, %0d objects closed, %0d rejected documents",
			chars_seen, keys_seen, objects_seen, rejected_docs);
		if (mismatches == 0 && pending_tokens.size() == 0) begin
			$display("json_object_array_tokenizer_tb: done, clean");
		end else begin
			$display("json_object_array_tokenizer_tb: done, errors");
		end
		$finish;
	end

endmodule

[json_object_array_tokenizer.f]
rtl/jtok_pkg.sv
rtl/jtok_if.sv
rtl/jtok_fsm.sv
rtl/json_object_array_tokenizer.sv
dv/json_object_array_tokenizer_tb.sv
